FILE: design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define GNOS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gnos assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define GNOS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gnos assertion failed");

`endif

FILE: design/gnos_pkg.sv
// Shared types and constants for the gradient noise octave sum block
package gnos_pkg;

	localparam int TABLE_SIZE_DEF  = 256;
	localparam int MAX_OCTAVES_DEF = 8;

	typedef enum logic [1:0] {
		OP_EVAL      = 2'd0,
		OP_LOAD_PERM = 2'd1,
		OP_LOAD_GRAD = 2'd2,
		OP_RSVD      = 2'd3
	} op_t;

	localparam logic [1:0] REG_BASE_FREQ = 2'd0;
	localparam logic [1:0] REG_OCTAVES   = 2'd1;
	localparam logic [1:0] REG_TURB      = 2'd2;

	localparam logic [31:0] BASE_FREQ_RST = 32'd65536;
	localparam logic [3:0]  OCTAVES_RST   = 4'd1;

	localparam int          LATTICE_OFFSET = 16;
	localparam int          FREQ_W         = 46;
	localparam logic [17:0] FREQ_STEP      = 18'd134940;
	localparam logic [14:0] WEIGHT_STEP    = 15'd31829;
	localparam logic [FREQ_W-1:0] FREQ_LIMIT = '1;
	localparam logic [16:0] WEIGHT_ONE     = 17'd65536;
	localparam logic [17:0] SMOOTH_K       = 18'd196608;
	localparam int          OUT_W          = 20;
	localparam int          OUT_MAX        = 524287;
	localparam int          OUT_MIN        = -524288;

	typedef struct packed {
		logic [31:0] base_freq;
		logic [3:0]  octaves;
		logic        turb;
	} gnos_cfg_t;

	typedef struct packed {
		logic        perm_we;
		logic        grad_we;
		logic [7:0]  perm_data;
		logic [47:0] grad_data;
	} tbl_wr_t;

endpackage

FILE: design/gnos_tables.sv
// Permutation and gradient memories, one write and one registered read port each
module gnos_tables import gnos_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF,
	localparam int AW = $clog2(TABLE_SIZE)
) (
	input  logic          clk,
	input  tbl_wr_t       wr,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] perm_raddr,
	output logic [7:0]    perm_rdata,
	input  logic [AW-1:0] grad_raddr,
	output logic [47:0]   grad_rdata
);

	logic [7:0]  perm_mem [TABLE_SIZE];
	logic [47:0] grad_mem [TABLE_SIZE];

	always_ff @(posedge clk) begin
		if (wr.perm_we) begin
			perm_mem[waddr] <= wr.perm_data;
		end
		perm_rdata <= perm_mem[perm_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.grad_we) begin
			grad_mem[waddr] <= wr.grad_data;
		end
		grad_rdata <= grad_mem[grad_raddr];
	end

endmodule

FILE: design/gnos_core.sv
// Octave sequencer and shared noise datapath reading the table memories
module gnos_core import gnos_pkg::*; #(
	parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
	parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
	localparam int AW = $clog2(TABLE_SIZE)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [31:0]      x_coord,
	input  logic signed [31:0]      y_coord,
	input  logic signed [31:0]      z_coord,
	input  gnos_cfg_t               cfg,
	output logic                    busy,
	output logic                    res_valid,
	input  logic                    res_ack,
	output logic signed [OUT_W-1:0] res_data,
	output logic [AW-1:0]           perm_raddr,
	input  logic [7:0]              perm_rdata,
	output logic [AW-1:0]           grad_raddr,
	input  logic [47:0]             grad_rdata
);

	localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
	localparam int VAL_W = 21;
	localparam int NZ_W  = VAL_W + 1;
	localparam int SUM_W = NZ_W + OCT_W + 1;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_POS   = 11'b00000000010,
		ST_FRAC  = 11'b00000000100,
		ST_SQ    = 11'b00000001000,
		ST_SM    = 11'b00000010000,
		ST_PERM  = 11'b00000100000,
		ST_GRAD  = 11'b00001000000,
		ST_LERP  = 11'b00010000000,
		ST_SCALE = 11'b00100000000,
		ST_ACC   = 11'b01000000000,
		ST_DONE  = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [OCT_W-1:0] oct_q, n_q, n_c;
	logic [2:0] pc_q;
	logic [3:0] gc_q;
	logic [2:0] lc_q;
	logic lp_q;
	logic v_s1, v_s2;

	logic signed [31:0] coord_q [3];
	logic [FREQ_W-1:0] freq_q;
	logic [16:0] weight_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [56:0] pl_s [3];
	logic signed [56:0] ph_s [3];
	logic [63:0] pos_c [3];
	logic [AW-1:0] c0_q [3];
	logic [AW-1:0] c1_c [3];
	logic [15:0] r0_q [3];
	logic [31:0] sq_s [3];
	logic [17:0] sm_fac [3];
	logic [33:0] sm_prod [3];
	logic [16:0] s_q [3];
	logic [AW-1:0] i_q, j_q;
	logic [AW-1:0] b_q [4];
	logic [2:0] gk_c, gk_s1, gk_s2;
	logic signed [32:0] gp_s2 [3];
	logic signed [34:0] dsum;
	logic signed [VAL_W-1:0] corner_q [8];
	logic signed [VAL_W-1:0] lerp_q [7];
	logic signed [VAL_W-1:0] la_c, lb_c, la_s;
	logic [16:0] lt_c;
	logic signed [VAL_W:0] ldiff;
	logic signed [39:0] lm_s;
	logic signed [VAL_W+1:0] tri3;
	logic signed [NZ_W-1:0] nz, nzm;
	logic signed [39:0] wp_s;
	logic [63:0] fm_s;
	logic [31:0] wm_s;
	logic [47:0] fnext;
	logic oct_last;

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign n_c = ({1'b0, cfg.octaves} > 5'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES)
		: OCT_W'(cfg.octaves);
	assign oct_last = (oct_q + 1'b1 == n_q);

	always_comb begin
		for (int d = 0; d < 3; d++) begin
			pos_c[d]   = 64'(pl_s[d]) + (64'(ph_s[d]) << 23);
			c1_c[d]    = c0_q[d] + 1'b1;
			sm_fac[d]  = SMOOTH_K - {1'b0, r0_q[d], 1'b0};
			sm_prod[d] = sq_s[d][31:16] * sm_fac[d];
		end
	end

	// permutation read schedule: i, j, then the four row hashes
	always_comb begin
		case (pc_q)
			3'd0:    perm_raddr = c0_q[0];
			3'd1:    perm_raddr = c1_c[0];
			3'd2:    perm_raddr = i_q + c0_q[1];
			3'd3:    perm_raddr = j_q + c0_q[1];
			3'd4:    perm_raddr = i_q + c1_c[1];
			3'd5:    perm_raddr = j_q + c1_c[1];
			default: perm_raddr = '0;
		endcase
	end

	// corner bit 0 selects x1, bit 1 y1, bit 2 z1
	assign gk_c       = gc_q[2:0];
	assign grad_raddr = b_q[gk_c[1:0]] + (gk_c[2] ? c1_c[2] : c0_q[2]);
	assign dsum = 35'(gp_s2[0]) + 35'(gp_s2[1]) + 35'(gp_s2[2]);

	always_comb begin
		case (lc_q)
			3'd0:    begin la_c = corner_q[0]; lb_c = corner_q[1]; lt_c = s_q[0]; end
			3'd1:    begin la_c = corner_q[2]; lb_c = corner_q[3]; lt_c = s_q[0]; end
			3'd2:    begin la_c = lerp_q[0];   lb_c = lerp_q[1];   lt_c = s_q[1]; end
			3'd3:    begin la_c = corner_q[4]; lb_c = corner_q[5]; lt_c = s_q[0]; end
			3'd4:    begin la_c = corner_q[6]; lb_c = corner_q[7]; lt_c = s_q[0]; end
			3'd5:    begin la_c = lerp_q[3];   lb_c = lerp_q[4];   lt_c = s_q[1]; end
			default: begin la_c = lerp_q[2];   lb_c = lerp_q[5];   lt_c = s_q[2]; end
		endcase
	end
	assign ldiff = lb_c - la_c;

	assign tri3  = (VAL_W+2)'(lerp_q[6]) + ((VAL_W+2)'(lerp_q[6]) <<< 1);
	assign nz    = NZ_W'(tri3 >>> 1);
	assign nzm   = (cfg.turb && nz < 0) ? -nz : nz;
	assign fnext = 48'((fm_s + 64'd32768) >> 16);

	always_comb begin
		if (sum_q > SUM_W'(OUT_MAX)) begin
			res_data = OUT_W'(OUT_MAX);
		end else if (sum_q < SUM_W'(OUT_MIN)) begin
			res_data = OUT_W'(OUT_MIN);
		end else begin
			res_data = OUT_W'(sum_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			oct_q   <= '0;
			n_q     <= '0;
			pc_q    <= '0;
			gc_q    <= '0;
			lc_q    <= '0;
			lp_q    <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_GRAD) && !gc_q[3];
			v_s2 <= v_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						oct_q   <= '0;
						n_q     <= n_c;
						state_q <= (n_c == '0) ? ST_DONE : ST_POS;
					end
				end
				ST_POS:  state_q <= ST_FRAC;
				ST_FRAC: state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_SM;
				ST_SM: begin
					pc_q    <= '0;
					state_q <= ST_PERM;
				end
				ST_PERM: begin
					pc_q <= pc_q + 1'b1;
					if (pc_q == 3'd6) begin
						gc_q    <= '0;
						state_q <= ST_GRAD;
					end
				end
				ST_GRAD: begin
					gc_q <= gc_q + 1'b1;
					if (gc_q == 4'd9) begin
						lc_q    <= '0;
						lp_q    <= 1'b0;
						state_q <= ST_LERP;
					end
				end
				ST_LERP: begin
					lp_q <= !lp_q;
					if (lp_q) begin
						lc_q <= lc_q + 1'b1;
						if (lc_q == 3'd6) begin
							state_q <= ST_SCALE;
						end
					end
				end
				ST_SCALE: state_q <= ST_ACC;
				ST_ACC: begin
					oct_q   <= oct_q + 1'b1;
					state_q <= oct_last ? ST_DONE : ST_POS;
				end
				ST_DONE: begin
					if (res_ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			coord_q[0] <= x_coord;
			coord_q[1] <= y_coord;
			coord_q[2] <= z_coord;
			freq_q     <= FREQ_W'(cfg.base_freq);
			weight_q   <= WEIGHT_ONE;
			sum_q      <= '0;
		end
		for (int d = 0; d < 3; d++) begin
			if (state_q == ST_POS) begin
				pl_s[d] <= coord_q[d] * $signed({1'b0, freq_q[22:0]});
				ph_s[d] <= coord_q[d] * $signed({1'b0, freq_q[45:23]});
			end
			if (state_q == ST_FRAC) begin
				c0_q[d] <= pos_c[d][32 +: AW] + AW'(LATTICE_OFFSET);
				r0_q[d] <= pos_c[d][31:16];
			end
			if (state_q == ST_SQ) begin
				sq_s[d] <= r0_q[d] * r0_q[d];
			end
			if (state_q == ST_SM) begin
				s_q[d] <= sm_prod[d][32:16];
			end
			gp_s2[d] <= $signed(grad_rdata[16*d +: 16]) * $signed({gk_s1[d], r0_q[d]});
		end
		if (state_q == ST_PERM) begin
			if (pc_q == 3'd1) begin
				i_q <= AW'(perm_rdata);
			end
			if (pc_q == 3'd2) begin
				j_q <= AW'(perm_rdata);
			end
			if (pc_q >= 3'd3) begin
				b_q[2'(pc_q - 3'd3)] <= AW'(perm_rdata);
			end
		end
		gk_s1 <= gk_c;
		gk_s2 <= gk_s1;
		if (v_s2) begin
			corner_q[gk_s2] <= VAL_W'(dsum >>> 14);
		end
		if (state_q == ST_LERP) begin
			if (!lp_q) begin
				lm_s <= $signed({1'b0, lt_c}) * ldiff;
				la_s <= la_c;
			end else begin
				lerp_q[lc_q] <= la_s + VAL_W'(lm_s >>> 16);
			end
		end
		if (state_q == ST_SCALE) begin
			wp_s <= nzm * $signed({1'b0, weight_q});
			fm_s <= freq_q * FREQ_STEP;
			wm_s <= weight_q * WEIGHT_STEP;
		end
		if (state_q == ST_ACC) begin
			sum_q    <= sum_q + SUM_W'(wp_s >>> 16);
			freq_q   <= (fnext > 48'(FREQ_LIMIT)) ? FREQ_LIMIT : fnext[FREQ_W-1:0];
			weight_q <= 17'((wm_s + 32'd32768) >> 16);
		end
	end

endmodule

FILE: design/gradient_noise_octave_sum.sv
// Top level: stream ports, register file, output register, tables and core
//
// Input stream s_*: one request per item. s_tuser carries the operation:
// evaluate a point, load a permutation entry or load a gradient entry.
// Loads are written into the tables at acceptance and give no result.
// An evaluate runs n octaves (none for n = 0) and then raises m_tvalid;
// the next request is taken once the core has handed its result to the output register.
// Each octave runs on the shared datapath: six permutation memory reads in a
// dependent chain, eight gradient reads through a three-lane multiply stage,
// seven interpolations and the weighting. s_tready is high whenever the core
// is idle, also while a result still waits in the output register; a stalled
// m_tready only holds the core once its next result is ready. Loads are taken
// one per cycle while the core is idle. Registers on the APB port must be
// written only while no evaluate is in flight; the block does not enforce it.
// Reset restores the registers and clears all handshake state; table
// contents are undefined until loaded, and no clearing pass is run.
module gradient_noise_octave_sum import gnos_pkg::*; #(
	parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
	parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] x_coord, [63:32] y_coord, [95:64] z_coord, [103:96] table_index,
	// [111:104] perm_value, [127:112] grad_x, [143:128] grad_y, [159:144] grad_z
	input  logic [159:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [19:0] noise_value, [23:20] zero
	output logic [23:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int AW = $clog2(TABLE_SIZE);

	gnos_cfg_t cfg_q;
	tbl_wr_t tbl_wr;
	logic s_acc, cfg_we, core_busy, res_valid, res_ack;
	logic [AW+7:0] idx_wide;
	logic [AW-1:0] waddr, perm_raddr, grad_raddr;
	logic [7:0] perm_rdata;
	logic [47:0] grad_rdata;
	logic signed [OUT_W-1:0] res_data;
	logic m_tvalid_q;
	logic [OUT_W-1:0] m_data_q;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_freq <= BASE_FREQ_RST;
			cfg_q.octaves   <= OCTAVES_RST;
			cfg_q.turb      <= 1'b0;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_BASE_FREQ: cfg_q.base_freq <= pwdata;
				REG_OCTAVES:   cfg_q.octaves   <= pwdata[3:0];
				REG_TURB:      cfg_q.turb      <= pwdata[0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_BASE_FREQ: prdata = cfg_q.base_freq;
			REG_OCTAVES:   prdata = {28'd0, cfg_q.octaves};
			REG_TURB:      prdata = {31'd0, cfg_q.turb};
			default:       prdata = '0;
		endcase
	end

	assign s_tready = !core_busy;
	assign s_acc    = s_tvalid && s_tready;
	assign idx_wide = (AW+8)'(s_tdata[103:96]);
	assign waddr    = idx_wide[AW-1:0];

	assign tbl_wr.perm_we   = s_acc && (s_tuser == OP_LOAD_PERM);
	assign tbl_wr.grad_we   = s_acc && (s_tuser == OP_LOAD_GRAD);
	assign tbl_wr.perm_data = s_tdata[111:104];
	assign tbl_wr.grad_data = s_tdata[159:112];

	gnos_tables #(.TABLE_SIZE(TABLE_SIZE)) u_tables (
		.clk        (clk),
		.wr         (tbl_wr),
		.waddr      (waddr),
		.perm_raddr (perm_raddr),
		.perm_rdata (perm_rdata),
		.grad_raddr (grad_raddr),
		.grad_rdata (grad_rdata)
	);

	gnos_core #(.TABLE_SIZE(TABLE_SIZE), .MAX_OCTAVES(MAX_OCTAVES)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (s_acc && (s_tuser == OP_EVAL)),
		.x_coord    ($signed(s_tdata[31:0])),
		.y_coord    ($signed(s_tdata[63:32])),
		.z_coord    ($signed(s_tdata[95:64])),
		.cfg        (cfg_q),
		.busy       (core_busy),
		.res_valid  (res_valid),
		.res_ack    (res_ack),
		.res_data   (res_data),
		.perm_raddr (perm_raddr),
		.perm_rdata (perm_rdata),
		.grad_raddr (grad_raddr),
		.grad_rdata (grad_rdata)
	);

	assign res_ack = res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ack) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			m_data_q <= res_data;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, m_data_q};

endmodule

FILE: design/gnos_checker.sv
// Port-level checker for the gradient noise octave sum block, with its bind
`include "assert_macros.svh"

module gnos_checker import gnos_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [23:0]  m_tdata,
	input logic         pready
);

	`GNOS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`GNOS_ASSERT_NXT(a_eval_busy, s_tvalid && s_tready && s_tuser == OP_EVAL, !s_tready)
	`GNOS_ASSERT_NXT(a_no_early_result, s_tvalid && s_tready && !m_tvalid, !m_tvalid)
	`GNOS_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[23:20] == 4'd0)
	`GNOS_ASSERT_IMP(a_apb_ready, 1'b1, pready)

endmodule

bind gradient_noise_octave_sum gnos_checker u_gnos_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);
